// ----- design/olist_pkg.sv -----
// Shared types and constants for the ordered list block.
// Used by the controller, the datapath, the top level and the checker.
package olist_pkg;

   // Field widths of the request and response transactions.
   localparam int REQ_W    = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // Largest number of match bits examined in one scan cycle.
   localparam int GROUP_MAX = 8;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec_update;
      logic scan_start;
      logic scan_next;
      logic scan_finish;
   } olist_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_is_find;
      logic scan_hit;
      logic scan_last;
   } olist_stat_type;

endpackage

// ----- design/olist_ctrl.sv -----
// Controller state machine for the ordered list block.
// Depends on olist_pkg for the command and status structs.
module olist_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  olist_pkg::olist_stat_type stat,
   output olist_pkg::olist_cmd_type  cmd
);
   import olist_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       rsp_load;

   // The response register can take a new transaction when it is empty or drained now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op_is_find) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else if (out_free) begin
               cmd.exec_update = 1'b1;
               rsp_load        = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit || stat.scan_last) begin
               if (out_free) begin
                  cmd.scan_finish = 1'b1;
                  rsp_load        = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid holds while the consumer stalls.
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/olist_dpath.sv -----
// Datapath for the ordered list block: entry cells, count, match scan and response registers.
// Depends on olist_pkg for widths, codes and the command and status structs.
module olist_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [olist_pkg::REQ_W-1:0]       req_type,
   input  logic [olist_pkg::POS_W-1:0]       req_position,
   input  logic                              req_at_end,
   input  logic signed [olist_pkg::VALUE_W-1:0] req_value,
   input  olist_pkg::olist_cmd_type          cmd,
   output olist_pkg::olist_stat_type         stat,
   output logic [olist_pkg::STATUS_W-1:0]    rsp_status,
   output logic [olist_pkg::FOUND_W-1:0]     rsp_found_index,
   output logic [olist_pkg::COUNT_W-1:0]     rsp_count
);
   import olist_pkg::*;

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP_W   = (CAPACITY < GROUP_MAX) ? CAPACITY : GROUP_MAX;
   localparam int NUM_GRP = (CAPACITY + GRP_W - 1) / GRP_W;
   localparam int PAD_W   = NUM_GRP * GRP_W;
   localparam int GCNT_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int FEXT_W  = IDX_W + FOUND_W;
   localparam int CEXT_W  = CNT_W + COUNT_W;

   // Captured request.
   logic [REQ_W-1:0]          op_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      at_end_ff;
   logic signed [VALUE_W-1:0] value_ff;

   // List state.
   logic signed [VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   // Match scan state.
   logic [PAD_W-1:0]  match_ff;
   logic [PAD_W-1:0]  match_in;
   logic [IDX_W-1:0]  base_ff;
   logic [GCNT_W-1:0] grp_ff;

   // Response registers.
   logic [STATUS_W-1:0] status_ff;
   logic [FOUND_W-1:0]  found_ff;
   logic [COUNT_W-1:0]  rcount_ff;

   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    eff_pos;
   logic                is_insert;
   logic                is_remove;
   logic                full;
   logic                bad_pos;
   logic                upd_ok;
   logic [STATUS_W-1:0] upd_status;
   logic [GRP_W-1:0]    low_grp;
   logic [IDX_W-1:0]    hit_off;
   logic [IDX_W-1:0]    hit_idx;
   logic [FEXT_W-1:0]   found_ext;
   logic [CEXT_W-1:0]   cnt_out_ext;

   // Request checks: effective position, full and range tests.
   assign is_insert = (op_ff == REQ_INSERT);
   assign is_remove = (op_ff == REQ_REMOVE);
   assign cnt_ext   = CMP_W'(count_ff);
   assign eff_pos   = at_end_ff ? (is_insert ? cnt_ext : cnt_ext - CMP_W'(1))
                                : CMP_W'(pos_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      bad_pos    = 1'b0;
      upd_ok     = 1'b0;
      upd_status = STATUS_OK;
      count_in   = count_ff;
      unique case (op_ff)
         REQ_INSERT: begin
            bad_pos = (eff_pos > cnt_ext);
            priority if (full) begin
               upd_status = STATUS_FULL;
            end else if (bad_pos) begin
               upd_status = STATUS_BADPOS;
            end else begin
               upd_ok   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_REMOVE: begin
            bad_pos = (count_ff == '0) || (eff_pos >= cnt_ext);
            if (bad_pos) begin
               upd_status = STATUS_BADPOS;
            end else begin
               upd_ok   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
            upd_status = STATUS_OK;
         end
      endcase
   end

   // Each cell picks its own value, the new value, its lower neighbor or its upper neighbor.
   always_comb begin
      entries_in = entries_ff;
      if (upd_ok) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (is_insert) begin
               if (CMP_W'(i) == eff_pos) begin
                  entries_in[i] = value_ff;
               end else if (i > 0) begin
                  if ((CMP_W'(i) > eff_pos) && (CMP_W'(i) <= cnt_ext)) begin
                     entries_in[i] = entries_ff[i-1];
                  end
               end
            end else if (is_remove) begin
               if (i < CAPACITY - 1) begin
                  if ((CMP_W'(i) >= eff_pos) && (CMP_W'(i + 1) < cnt_ext)) begin
                     entries_in[i] = entries_ff[i+1];
                  end
               end
            end
         end
      end
   end

   // Parallel compare of every live cell against the search value.
   always_comb begin
      match_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (entries_ff[i] == value_ff) && (CMP_W'(i) < cnt_ext);
      end
   end

   // Lowest set bit of the current group of match bits.
   assign low_grp = match_ff[GRP_W-1:0];

   always_comb begin
      hit_off = '0;
      for (int g = GRP_W - 1; g >= 0; g--) begin
         if (low_grp[g]) begin
            hit_off = IDX_W'(g);
         end
      end
   end

   assign hit_idx = base_ff + hit_off;

   assign stat.op_is_find = (op_ff == REQ_FIND);
   assign stat.scan_hit   = |low_grp;
   assign stat.scan_last  = (grp_ff == GCNT_W'(NUM_GRP - 1));

   // Narrow the internal index and count to the response field widths.
   assign found_ext   = FEXT_W'(hit_idx);
   assign cnt_out_ext = CEXT_W'(count_in);

   // Captured request and list cells.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_type;
         pos_ff    <= req_position;
         at_end_ff <= req_at_end;
         value_ff  <= req_value;
      end
      if (cmd.exec_update) begin
         entries_ff <= entries_in;
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec_update) begin
         count_ff <= count_in;
      end
   end

   // Match vector moves down one group per scan cycle.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         match_ff <= match_in;
         base_ff  <= '0;
         grp_ff   <= '0;
      end else if (cmd.scan_next) begin
         match_ff <= match_ff >> GRP_W;
         base_ff  <= base_ff + IDX_W'(GRP_W);
         grp_ff   <= grp_ff + GCNT_W'(1);
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.exec_update) begin
         status_ff <= upd_status;
         found_ff  <= '0;
         rcount_ff <= cnt_out_ext[COUNT_W-1:0];
      end else if (cmd.scan_finish) begin
         status_ff <= stat.scan_hit ? STATUS_OK : STATUS_NOTFOUND;
         found_ff  <= stat.scan_hit ? found_ext[FOUND_W-1:0] : '0;
         rcount_ff <= cnt_out_ext[COUNT_W-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_index = found_ff;
   assign rsp_count       = rcount_ff;

endmodule

// ----- design/ordered_list_insert_remove_find.sv -----
// Ordered list of up to CAPACITY signed 32-bit values with insert, remove, find and clear.
// Each request transaction yields one response transaction carrying status, match index and
// the entry count after the request. Insert, remove and clear update the list and load the
// response directly; a find responds after a scan state in which the registered match
// vector is scanned eight entries per cycle. One request is worked on at a time; a new one is
// accepted once the previous result sits in the output register, even if it is not yet taken.
// Entry contents are not cleared at reset; only entries below the count are ever read.
module ordered_list_insert_remove_find #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [olist_pkg::REQ_W-1:0]          req_type,
   input  logic [olist_pkg::POS_W-1:0]          req_position,
   input  logic                                 req_at_end,
   input  logic signed [olist_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [olist_pkg::STATUS_W-1:0]       rsp_status,
   output logic [olist_pkg::FOUND_W-1:0]        rsp_found_index,
   output logic [olist_pkg::COUNT_W-1:0]        rsp_count
);
   import olist_pkg::*;

   olist_cmd_type  cmd;
   olist_stat_type stat;

   // Sequencing of each transaction.
   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // List storage, checks and search.
   olist_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_at_end      (req_at_end),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

endmodule

// ----- design/olist_checker.sv -----
// Port-level checks for the ordered list block, attached to the top level by bind.
// Depends on olist_pkg for status codes and field widths.
module olist_checker #(
   parameter int CAPACITY = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [olist_pkg::STATUS_W-1:0]       rsp_status,
   input logic [olist_pkg::FOUND_W-1:0]        rsp_found_index,
   input logic [olist_pkg::COUNT_W-1:0]        rsp_count
);
   import olist_pkg::*;

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_index) && $stable(rsp_count))
      else $error("stalled response changed");

   // Requests are worked one at a time, so an accepted request stalls the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on back-to-back cycles");

   // Only a successful find reports a nonzero index.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_found_index == '0))
      else $error("nonzero index on failed request");

   // A full list reports a count equal to its capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_count == COUNT_W'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

bind ordered_list_insert_remove_find olist_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
